// File: sv/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W     = 16;
  localparam int CFG_W      = 7;

  // configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // placement policies
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_LOADED    = 2'd0,
    STAT_ALLOCATED = 2'd1,
    STAT_NOALLOC   = 2'd2,
    STAT_RESTARTED = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_COPY,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic  load;   // store a block size at transfer
    logic  start;  // begin a scan or a copy sweep
    logic  scan;
    logic  copy;
    logic  pick;   // commit the chosen block
    logic  fin;    // move the result into the output register
    stat_t res;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic copy_done;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// File: sv/fpba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer for loads, scans, commits and restart sweeps.
// ----------------------------------------------------------------------------
module fpba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_kind,
  output logic               in_ready,
  input  fpba_pkg::sts_t     sts,
  output fpba_pkg::cmd_t     cmd
);

  fpba_pkg::state_t state_r, state_nxt;
  fpba_pkg::stat_t  res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpba_pkg::ST_IDLE;
      res_r   <= fpba_pkg::STAT_LOADED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.res   = res_r;
    unique case (state_r)
      fpba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (fpba_pkg::kind_t'(in_kind))
            fpba_pkg::KIND_LOAD: begin
              cmd.load  = 1'b1;
              res_nxt   = fpba_pkg::STAT_LOADED;
              state_nxt = fpba_pkg::ST_FIN;
            end
            fpba_pkg::KIND_REQUEST: begin
              cmd.start = 1'b1;
              state_nxt = fpba_pkg::ST_SCAN;
            end
            fpba_pkg::KIND_RESTART: begin
              cmd.start = 1'b1;
              state_nxt = fpba_pkg::ST_COPY;
            end
            default: state_nxt = fpba_pkg::ST_IDLE;
          endcase
        end
      end
      fpba_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            state_nxt = fpba_pkg::ST_PICK;
          end else begin
            res_nxt   = fpba_pkg::STAT_NOALLOC;
            state_nxt = fpba_pkg::ST_FIN;
          end
        end
      end
      fpba_pkg::ST_PICK: begin
        cmd.pick  = 1'b1;
        res_nxt   = fpba_pkg::STAT_ALLOCATED;
        state_nxt = fpba_pkg::ST_FIN;
      end
      fpba_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) begin
          res_nxt   = fpba_pkg::STAT_RESTARTED;
          state_nxt = fpba_pkg::ST_FIN;
        end
      end
      fpba_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = fpba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpba_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/fpba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_dp
// Block tables, config registers, fit compare and output register.
// ----------------------------------------------------------------------------
module fpba_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fpba_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [fpba_pkg::IDX_W-1:0]  in_block_index,
  input  logic [fpba_pkg::SIZE_W-1:0] in_size,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [fpba_pkg::IDX_W-1:0]  out_chosen_block,
  output logic [fpba_pkg::SIZE_W-1:0] out_block_size,
  output logic [fpba_pkg::SIZE_W-1:0] out_free_left,
  input  fpba_pkg::cmd_t              cmd,
  output fpba_pkg::sts_t              sts
);

  localparam logic [fpba_pkg::CNT_W-1:0] MAX_CNT = fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS);

  logic [fpba_pkg::SIZE_W-1:0] orig_mem [fpba_pkg::MAX_BLOCKS];
  logic [fpba_pkg::SIZE_W-1:0] free_mem [fpba_pkg::MAX_BLOCKS];

  logic [1:0]                  mode_r;
  logic [fpba_pkg::CFG_W-1:0]  bcount_r;
  logic [fpba_pkg::CNT_W-1:0]  count_r;
  logic [fpba_pkg::CNT_W-1:0]  idx_r;
  logic                        rd_vld_r;
  logic [fpba_pkg::IDX_W-1:0]  rd_idx_r;
  logic [fpba_pkg::SIZE_W-1:0] rd_free_r;
  logic [fpba_pkg::SIZE_W-1:0] rd_orig_r;
  logic                        found_r;
  logic [fpba_pkg::IDX_W-1:0]  pick_r;
  logic [fpba_pkg::SIZE_W-1:0] best_r;
  logic [fpba_pkg::SIZE_W-1:0] req_r;
  logic [fpba_pkg::IDX_W-1:0]  bidx_r;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [fpba_pkg::IDX_W-1:0]  out_chosen_r;
  logic [fpba_pkg::SIZE_W-1:0] out_bsize_r;
  logic [fpba_pkg::SIZE_W-1:0] out_left_r;

  logic                        scan_rd;
  logic                        copy_rd;
  logic                        take;
  logic [fpba_pkg::SIZE_W-1:0] left;
  logic                        fw_en;
  logic [fpba_pkg::IDX_W-1:0]  fw_addr;
  logic [fpba_pkg::SIZE_W-1:0] fw_data;
  logic                        or_en;
  logic [fpba_pkg::IDX_W-1:0]  or_addr;

  assign scan_rd = cmd.scan && (idx_r < count_r);
  assign copy_rd = cmd.copy && (idx_r < MAX_CNT);
  assign left    = best_r - req_r;

  // a fitting block wins if it is the first, or strictly better under the policy
  always_comb begin
    take = 1'b0;
    if (cmd.scan && rd_vld_r && (rd_free_r >= req_r)) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (mode_r == fpba_pkg::MODE_BEST) begin
        take = rd_free_r < best_r;
      end else if (mode_r == fpba_pkg::MODE_WORST) begin
        take = rd_free_r > best_r;
      end
    end
  end

  // free-space write port: load, restart sweep, commit
  always_comb begin
    fw_en   = 1'b0;
    fw_addr = in_block_index;
    fw_data = in_size;
    if (cmd.load) begin
      fw_en = 1'b1;
    end else if (cmd.copy && rd_vld_r) begin
      fw_en   = 1'b1;
      fw_addr = rd_idx_r;
      fw_data = rd_orig_r;
    end else if (cmd.pick) begin
      fw_en   = 1'b1;
      fw_addr = pick_r;
      fw_data = left;
    end
  end

  assign or_en   = copy_rd || cmd.pick;
  assign or_addr = cmd.pick ? pick_r : idx_r[fpba_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (fw_en) begin
      free_mem[fw_addr] <= fw_data;
    end
    if (scan_rd) begin
      rd_free_r <= free_mem[idx_r[fpba_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      orig_mem[in_block_index] <= in_size;
    end
    if (or_en) begin
      rd_orig_r <= orig_mem[or_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= fpba_pkg::MODE_FIRST;
      bcount_r <= fpba_pkg::CFG_W'(fpba_pkg::MAX_BLOCKS);
    end else if (cfg_we) begin
      if (cfg_index == fpba_pkg::CFG_FIT_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end else begin
        bcount_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.start) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.scan || cmd.copy) begin
      rd_vld_r <= scan_rd || copy_rd;
      if (scan_rd || copy_rd) begin
        idx_r <= idx_r + 1'b1;
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.load) begin
      req_r  <= in_size;
      bidx_r <= in_block_index;
    end
    if (cmd.start) begin
      count_r <= (bcount_r > fpba_pkg::CFG_W'(fpba_pkg::MAX_BLOCKS)) ? MAX_CNT
                 : fpba_pkg::CNT_W'(bcount_r);
    end
    if (scan_rd || copy_rd) begin
      rd_idx_r <= idx_r[fpba_pkg::IDX_W-1:0];
    end
    if (take) begin
      pick_r <= rd_idx_r;
      best_r <= rd_free_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status_r <= cmd.res;
      case (cmd.res)
        fpba_pkg::STAT_LOADED: begin
          out_chosen_r <= bidx_r;
          out_bsize_r  <= req_r;
          out_left_r   <= req_r;
        end
        fpba_pkg::STAT_ALLOCATED: begin
          out_chosen_r <= pick_r;
          out_bsize_r  <= rd_orig_r;
          out_left_r   <= left;
        end
        default: begin
          out_chosen_r <= '0;
          out_bsize_r  <= '0;
          out_left_r   <= '0;
        end
      endcase
    end
  end

  assign sts.scan_done = !(idx_r < count_r) && !rd_vld_r;
  assign sts.copy_done = !(idx_r < MAX_CNT) && !rd_vld_r;
  assign sts.found     = found_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_block = out_chosen_r;
  assign out_block_size   = out_bsize_r;
  assign out_free_left    = out_left_r;

endmodule

// File: sv/fit_policy_block_allocator_unit.sv
`timescale 1ns / 1ps
// A load goes straight to the result; a request scans block_count (max 64)
//   blocks, one table read per block through the free-space RAM port, then a
//   commit of the chosen block when one fits; restart sweeps all MAX_BLOCKS.
// One item at a time; the next item is accepted the cycle after the result
//   enters the output register. Tables are undefined until loaded; reset clears
//   control, sets fit_mode to first fit and block_count to 64.
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// First/best/worst fit allocator over a table of memory blocks.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fpba_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [fpba_pkg::IDX_W-1:0]  in_block_index,
  input  logic [fpba_pkg::SIZE_W-1:0] in_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [fpba_pkg::IDX_W-1:0]  out_chosen_block,
  output logic [fpba_pkg::SIZE_W-1:0] out_block_size,
  output logic [fpba_pkg::SIZE_W-1:0] out_free_left
);

  fpba_pkg::cmd_t cmd;
  fpba_pkg::sts_t sts;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_block_index   (in_block_index),
    .in_size          (in_size),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_chosen_block (out_chosen_block),
    .out_block_size   (out_block_size),
    .out_free_left    (out_free_left),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
